// File: design/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

	// decode phases; codes beyond PH_ERR are treated as error
	typedef enum logic [2:0] {
		PH_OPEN = 3'd0,
		PH_TEXT = 3'd1,
		PH_ESC  = 3'd2,
		PH_HEX  = 3'd3,
		PH_DONE = 3'd4,
		PH_ERR  = 3'd5
	} phase_t;

	// token status carried on every output word
	typedef enum logic [1:0] {
		OC_RUN = 2'd0,
		OC_OK  = 2'd1,
		OC_ERR = 2'd2
	} outcome_t;

	localparam int unsigned MAX_BYTES = 3;
	localparam int unsigned CP_HEX_DIGITS = 4;

	// decoded bytes of one input word, handed to the output stage
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [1:0]                nbytes;
		outcome_t                  outcome;
	} dec_t;

endpackage
`default_nettype wire

// File: design/json_string_unescape_top.sv
// JSON string unescaper: takes one raw byte of a quoted string token per word
// (s_tlast on the token's last byte) and streams out the decoded bytes. Escapes
// \b \f \n \r \t \" \\ \/ become one byte; \u or \U with four hex digits becomes
// one to three UTF-8 bytes (NUL emits nothing, surrogates emit '?'). Every input
// word yields one to three output words; m_tlast marks the last of them. A word
// with no decoded byte has m_tuser[0] low. m_tuser[2:1] gives the outcome after
// that input word: 0 parsing, 1 closed, 2 error; close and error are sticky until
// reset. Throughput is one input word per cycle, except that an escape producing
// two or three UTF-8 bytes holds the input while the output register drains it,
// and m_tready low stalls the input once both registers are full. An input word
// passes through the input register, then the result register, to the output.
`default_nettype none
module json_string_unescape_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] s_tdata,   // in_byte
	input  wire logic       s_tlast,   // final_byte
	input  wire logic       s_tvalid,
	output logic            s_tready,
	output logic [7:0]      m_tdata,   // out_byte
	output logic [2:0]      m_tuser,   // [0] byte_valid, [2:1] outcome
	output logic            m_tlast,   // run_end
	output logic            m_tvalid,
	input  wire logic       m_tready
);
	import jsu_pkg::*;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       free;
	logic       load;
	dec_t       dec;

	assign load     = v_s1 && free;
	assign s_tready = !v_s1 || free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (load) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	jsu_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.in_byte    (byte_s1),
		.final_byte (last_s1),
		.dec        (dec)
	);

	jsu_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.dec      (dec),
		.free     (free),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

endmodule
`default_nettype wire

// File: design/jsu_parse.sv
`default_nettype none
module jsu_parse (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         load,
	input  wire logic [7:0]   in_byte,
	input  wire logic         final_byte,
	output jsu_pkg::dec_t     dec
);
	import jsu_pkg::*;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_LU    = 8'h75;
	localparam logic [7:0] CH_UU    = 8'h55;
	localparam logic [1:0] LAST_DIGIT = 2'(CP_HEX_DIGITS - 1);

	phase_t      phase_q, phase_d;
	logic [15:0] acc_q, acc_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [15:0] cp;
	logic [3:0]  hex_d;
	logic        hex_ok;

	// strict hex digit: 0-9, a-f, A-F
	always_comb begin
		hex_ok = 1'b1;
		hex_d  = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39)
			hex_d = 4'(in_byte - 8'h30);
		else if (in_byte >= 8'h61 && in_byte <= 8'h66)
			hex_d = 4'(in_byte - 8'h57);
		else if (in_byte >= 8'h41 && in_byte <= 8'h46)
			hex_d = 4'(in_byte - 8'h37);
		else
			hex_ok = 1'b0;
	end

	assign cp = {acc_q[11:0], hex_d};

	// next state, decoded bytes and outcome after this word
	always_comb begin
		phase_d     = phase_q;
		acc_d       = acc_q;
		cnt_d       = cnt_q;
		dec.bytes   = '0;
		dec.nbytes  = 2'd0;
		unique case (phase_q)
			PH_OPEN: begin
				phase_d = (in_byte == CH_QUOTE && !final_byte) ? PH_TEXT : PH_ERR;
			end
			PH_TEXT: begin
				if (in_byte == CH_QUOTE) begin
					phase_d = PH_DONE;
				end else if (in_byte == CH_BSL) begin
					phase_d = final_byte ? PH_ERR : PH_ESC;
				end else begin
					dec.bytes[0] = in_byte;
					dec.nbytes   = 2'd1;
					if (final_byte) phase_d = PH_ERR;
				end
			end
			PH_ESC: begin
				phase_d    = PH_TEXT;
				dec.nbytes = 2'd1;
				unique case (in_byte)
					CH_B:     dec.bytes[0] = 8'h08;
					CH_F:     dec.bytes[0] = 8'h0C;
					CH_N:     dec.bytes[0] = 8'h0A;
					CH_R:     dec.bytes[0] = 8'h0D;
					CH_T:     dec.bytes[0] = 8'h09;
					CH_QUOTE, CH_BSL, CH_SLASH: dec.bytes[0] = in_byte;
					CH_LU, CH_UU: begin
						dec.nbytes = 2'd0;
						phase_d    = PH_HEX;
						acc_d      = '0;
						cnt_d      = '0;
					end
					default: begin
						dec.nbytes = 2'd0;
						phase_d    = PH_ERR;
					end
				endcase
				if (final_byte) phase_d = PH_ERR;
			end
			PH_HEX: begin
				if (!hex_ok) begin
					phase_d = PH_ERR;
				end else begin
					acc_d = cp;
					if (cnt_q == LAST_DIGIT) begin
						cnt_d   = '0;
						phase_d = PH_TEXT;
						// UTF-8 encode; NUL emits nothing, surrogates emit '?'
						if (cp == 16'h0000) begin
							dec.nbytes = 2'd0;
						end else if (cp[15:11] == 5'b11011) begin
							dec.bytes[0] = 8'h3F;
							dec.nbytes   = 2'd1;
						end else if (cp < 16'h0080) begin
							dec.bytes[0] = cp[7:0];
							dec.nbytes   = 2'd1;
						end else if (cp < 16'h0800) begin
							dec.bytes[0] = {3'b110, cp[10:6]};
							dec.bytes[1] = {2'b10, cp[5:0]};
							dec.nbytes   = 2'd2;
						end else begin
							dec.bytes[0] = {4'b1110, cp[15:12]};
							dec.bytes[1] = {2'b10, cp[11:6]};
							dec.bytes[2] = {2'b10, cp[5:0]};
							dec.nbytes   = 2'd3;
						end
					end else begin
						cnt_d = cnt_q + 2'd1;
					end
					if (final_byte) phase_d = PH_ERR;
				end
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = PH_ERR;
			end
		endcase
		if (phase_d == PH_DONE)     dec.outcome = OC_OK;
		else if (phase_d == PH_ERR) dec.outcome = OC_ERR;
		else                        dec.outcome = OC_RUN;
	end

	// parser state advances when the word moves to the output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPEN;
			acc_q   <= '0;
			cnt_q   <= '0;
		end else if (load) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule
`default_nettype wire

// File: design/jsu_emit.sv
`default_nettype none
module jsu_emit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire jsu_pkg::dec_t dec,
	output logic               free,
	output logic [7:0]         m_tdata,   // out_byte
	output logic [2:0]         m_tuser,   // [0] byte_valid, [2:1] outcome
	output logic               m_tlast,   // run_end
	output logic               m_tvalid,
	input  wire logic          m_tready
);
	import jsu_pkg::*;

	logic                      v_s2;
	logic [MAX_BYTES-1:0][7:0] bytes_s2;
	logic [1:0]                last_s2;
	logic                      bv_s2;
	outcome_t                  oc_s2;
	logic [1:0]                idx_q;
	logic                      take, done;

	assign take = m_tvalid && m_tready;
	assign done = take && (idx_q == last_s2);
	assign free = !v_s2 || done;

	// result register, drained one word per handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			v_s2  <= 1'b1;
			idx_q <= '0;
		end else if (done) begin
			v_s2  <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s2 <= dec.bytes;
			bv_s2    <= (dec.nbytes != 2'd0);
			last_s2  <= (dec.nbytes == 2'd0) ? 2'd0 : dec.nbytes - 2'd1;
			oc_s2    <= dec.outcome;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = bytes_s2[idx_q];
	assign m_tuser  = {oc_s2, bv_s2};
	assign m_tlast  = (idx_q == last_s2);

endmodule
`default_nettype wire
